FILE: hdl/least_service_ratio_scheduler_defines.svh
// Assertion macros shared by the least service ratio scheduler modules.
`ifndef LEAST_SERVICE_RATIO_SCHEDULER_DEFINES_SVH
`define LEAST_SERVICE_RATIO_SCHEDULER_DEFINES_SVH

// Check that an expression holds at every clock edge outside reset.
`define LSR_ASSERT_HOLDS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("lsr: invariant violated");

// Check that a condition implies a consequence in the same cycle.
`define LSR_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lsr: same-cycle implication violated");

// Check that a condition implies a consequence in the next cycle.
`define LSR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lsr: next-cycle implication violated");

`endif

FILE: hdl/lsr_pkg.sv
// Shared types and constants of the least service ratio scheduler.
`timescale 1ns / 1ps

package lsr_pkg;

    // Request kinds carried in the input tuser field
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_CANCEL = 2'd2;

    // Upper bound on frames per elapsed millisecond for a slot to be eligible
    localparam logic [26:0] RATIO_CEIL = 27'd100000000;

    // Reset value of the grant size register
    localparam logic [15:0] GRANT_SIZE_RESET = 16'd100;

    // Stream bus widths
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 48;

    // One slot entry as kept in the slot RAM
    typedef struct packed {
        logic [31:0] frames_left;
        logic [31:0] frames_done;
        logic [15:0] next_frame;
        logic [31:0] start_ms;
    } slot_entry_t;

    // One result item, last field in the lowest bits
    typedef struct packed {
        logic        slot_released;
        logic [15:0] grant_count;
        logic [15:0] grant_first;
        logic [3:0]  grant_slot;
        logic        grant_valid;
        logic [3:0]  assigned_slot;
        logic        table_full;
        logic        add_accepted;
    } result_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic idx_inc;
        logic ram_rd;
        logic mul_en;
        logic cmp_en;
        logic add_commit;
        logic add_full;
        logic tick_commit;
        logic other_commit;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic slot_free;
        logic idx_last;
        logic can_out;
    } status_t;

endpackage

FILE: hdl/least_service_ratio_scheduler.sv
// Top level of the least service ratio scheduler.
//
// Keeps SLOT_COUNT stream slots and handles one request at a time: add (tuser 0) takes the
// lowest free slot, cancel (tuser 2) marks an active slot, tick (tuser 1) picks the active
// slot with the lowest frames_done / (elapsed + 1) and grants up to grant_size frames.
// Every request gives exactly one result transfer. An add walks over the slot flags one
// slot per cycle; a tick reads each slot through the single read port of the slot RAM,
// then multiplies and compares it in the shared multiply-and-compare unit, reading the
// next slot during the compare. The result register frees the input side at once; a
// request finishes only once the previous result has been taken. grant_size is written
// through cfg_wr_en / cfg_wr_data; the user must write it only while the block is idle,
// and the block itself does not enforce this.
`timescale 1ns / 1ps

module least_service_ratio_scheduler #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Requests
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] now_ms, [63:32] frame_total, [79:64] first_frame, [83:80] target_slot
    input  logic [lsr_pkg::IN_DATA_W-1:0]   s_tdata,
    // [1:0] req_type
    input  logic [1:0]                      s_tuser,
    // Results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] add_accepted, [1] table_full, [5:2] assigned_slot, [6] grant_valid,
    // [10:7] grant_slot, [26:11] grant_first, [42:27] grant_count, [43] slot_released
    output logic [lsr_pkg::OUT_DATA_W-1:0]  m_tdata,
    // grant_size register
    input  logic                            cfg_wr_en,
    input  logic [15:0]                     cfg_wr_data
);

    lsr_pkg::cmd_t    cmd;
    lsr_pkg::status_t status;

    lsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    lsr_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

FILE: hdl/lsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/lsr_ctrl.sv
// Controller state machine of the least service ratio scheduler.
`timescale 1ns / 1ps
`include "least_service_ratio_scheduler_defines.svh"

module lsr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [1:0]        s_tuser,   // [1:0] req_type
    input  lsr_pkg::status_t  status,
    output lsr_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_RD,
        S_MUL,
        S_CMP,
        S_UPD,
        S_MISC
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequence the requests
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    unique case (s_tuser)
                        lsr_pkg::REQ_ADD:  state_next = S_ADD;
                        lsr_pkg::REQ_TICK: state_next = S_RD;
                        default:           state_next = S_MISC;
                    endcase
                end
            end
            S_ADD: begin
                // Walk the active bits until a free slot turns up
                if (status.slot_free) begin
                    if (status.can_out) begin
                        cmd.add_commit = 1'b1;
                        state_next     = S_IDLE;
                    end
                end else if (status.idx_last) begin
                    if (status.can_out) begin
                        cmd.add_full = 1'b1;
                        state_next   = S_IDLE;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_RD: begin
                cmd.ram_rd = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = S_CMP;
            end
            S_CMP: begin
                // Compare this slot and, unless it is the last, fetch the next one
                cmd.cmp_en = 1'b1;
                if (status.idx_last) begin
                    state_next = S_UPD;
                end else begin
                    cmd.idx_inc = 1'b1;
                    cmd.ram_rd  = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_UPD: begin
                if (status.can_out) begin
                    cmd.tick_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_MISC: begin
                if (status.can_out) begin
                    cmd.other_commit = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `LSR_ASSERT_HOLDS(a_one_commit, aclk, aresetn, $onehot0({cmd.add_commit, cmd.add_full, cmd.tick_commit, cmd.other_commit}))

endmodule

FILE: hdl/lsr_datapath.sv
// Datapath of the least service ratio scheduler: slot table, comparator, result register.
`timescale 1ns / 1ps
`include "least_service_ratio_scheduler_defines.svh"

module lsr_datapath #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [lsr_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [1:0]                       s_tuser,
    input  logic                             cfg_wr_en,
    input  logic [15:0]                      cfg_wr_data,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lsr_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  lsr_pkg::cmd_t                    cmd,
    output lsr_pkg::status_t                 status
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int EW = $bits(lsr_pkg::slot_entry_t);

    // Configuration and latched request
    logic [15:0]          grant_reg;
    logic [1:0]           type_reg;
    logic [31:0]          now_reg;
    logic [31:0]          total_reg;
    logic [15:0]          first_reg;
    logic [3:0]           target_reg;

    // Slot flags
    logic [SLOT_COUNT-1:0] active_reg;
    logic [SLOT_COUNT-1:0] cancel_reg;

    // Scan state
    logic [SW-1:0]          idx_reg;
    logic                   found_reg;
    logic [SW-1:0]          best_idx_reg;
    lsr_pkg::slot_entry_t   best_reg;
    logic [31:0]            best_elapsed_reg;
    lsr_pkg::slot_entry_t   cand_reg;
    logic [31:0]            cand_elapsed_reg;
    logic [63:0]            prod_cand_reg;
    logic [63:0]            prod_best_reg;
    logic [59:0]            ceil_reg;

    // Result register
    logic                   m_valid_reg;
    lsr_pkg::result_t       res_reg;
    lsr_pkg::result_t       res_next;

    // RAM ports
    logic                   ram_we;
    logic [SW-1:0]          ram_waddr;
    lsr_pkg::slot_entry_t   ram_wentry;
    logic [SW-1:0]          ram_raddr;
    logic [EW-1:0]          ram_rdata;
    lsr_pkg::slot_entry_t   rd_entry;

    // Combinational helpers
    logic [31:0]            rd_elapsed;
    logic [32:0]            rd_den;
    logic [64:0]            lhs;
    logic [64:0]            rhs;
    logic                   ceil_ok;
    logic                   take;
    logic                   best_cancel;
    logic [15:0]            count;
    logic [31:0]            left_new;
    logic                   release_best;
    logic                   upd_fire;
    logic                   res_load;
    logic [8:0]             target_ext;
    logic [SW-1:0]          target_idx;
    logic                   cancel_ok;
    lsr_pkg::slot_entry_t   add_entry;
    lsr_pkg::slot_entry_t   upd_entry;

    assign rd_entry = lsr_pkg::slot_entry_t'(ram_rdata);

    lsr_ram #(
        .WIDTH (EW),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (EW'(ram_wentry)),
        .rd_en   (cmd.ram_rd),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Read the current slot, or the next one while the current one is compared
    assign ram_raddr = cmd.idx_inc ? idx_reg + SW'(1) : idx_reg;

    // Elapsed time and denominator of the slot just read
    assign rd_elapsed = now_reg - rd_entry.start_ms;
    assign rd_den     = {1'b0, rd_elapsed} + 33'd1;

    // Cross-multiplied ratio test and ceiling test
    assign lhs     = 65'(prod_cand_reg) + 65'(cand_reg.frames_done);
    assign rhs     = 65'(prod_best_reg) + 65'(best_reg.frames_done);
    assign ceil_ok = 60'(cand_reg.frames_done) < ceil_reg;
    assign take    = cmd.cmp_en && active_reg[idx_reg] && (found_reg ? (lhs < rhs) : ceil_ok);

    // Grant for the chosen slot
    assign best_cancel  = cancel_reg[best_idx_reg];
    assign count        = best_cancel ? 16'd0 :
                          ((best_reg.frames_left < 32'(grant_reg)) ?
                           best_reg.frames_left[15:0] : grant_reg);
    assign left_new     = best_reg.frames_left - 32'(count);
    assign release_best = best_cancel || (left_new == 32'd0);
    assign upd_fire     = cmd.tick_commit && found_reg;

    // Cancel target check
    assign target_ext = {5'd0, target_reg};
    assign target_idx = target_ext[SW-1:0];
    assign cancel_ok  = (type_reg == lsr_pkg::REQ_CANCEL) &&
                        (target_ext < 9'(SLOT_COUNT)) && active_reg[target_idx];

    // New and updated slot entries
    always_comb begin
        add_entry.frames_left = total_reg;
        add_entry.frames_done = 32'd0;
        add_entry.next_frame  = first_reg;
        add_entry.start_ms    = now_reg;

        upd_entry.frames_left = left_new;
        upd_entry.frames_done = best_reg.frames_done + 32'(count);
        upd_entry.next_frame  = best_reg.next_frame + count;
        upd_entry.start_ms    = best_reg.start_ms;
    end

    assign ram_we     = cmd.add_commit || upd_fire;
    assign ram_waddr  = cmd.add_commit ? idx_reg : best_idx_reg;
    assign ram_wentry = cmd.add_commit ? add_entry : upd_entry;

    // Build the result item
    always_comb begin
        res_next = '0;
        if (cmd.add_commit) begin
            res_next.add_accepted  = 1'b1;
            res_next.assigned_slot = 4'(idx_reg);
        end
        if (cmd.add_full) begin
            res_next.table_full = 1'b1;
        end
        if (upd_fire) begin
            res_next.grant_valid   = 1'b1;
            res_next.grant_slot    = 4'(best_idx_reg);
            res_next.grant_first   = best_reg.next_frame;
            res_next.grant_count   = count;
            res_next.slot_released = release_best;
        end
    end

    assign res_load = cmd.add_commit || cmd.add_full || cmd.tick_commit || cmd.other_commit;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grant_reg   <= lsr_pkg::GRANT_SIZE_RESET;
            active_reg  <= '0;
            cancel_reg  <= '0;
            idx_reg     <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                grant_reg <= cfg_wr_data;
            end
            // Advance the scan index
            if (cmd.capture) begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + SW'(1);
            end
            if (take) begin
                found_reg <= 1'b1;
            end
            // Update slot flags
            if (cmd.add_commit) begin
                active_reg[idx_reg] <= 1'b1;
                cancel_reg[idx_reg] <= 1'b0;
            end
            if (upd_fire && release_best) begin
                active_reg[best_idx_reg] <= 1'b0;
                cancel_reg[best_idx_reg] <= 1'b0;
            end
            if (cmd.other_commit && cancel_ok) begin
                cancel_reg[target_idx] <= 1'b1;
            end
            // Output transfer
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            type_reg   <= s_tuser;
            now_reg    <= s_tdata[31:0];
            total_reg  <= s_tdata[63:32];
            first_reg  <= s_tdata[79:64];
            target_reg <= s_tdata[83:80];
        end
        // Products for the slot just read, against the best so far
        if (cmd.mul_en) begin
            cand_reg         <= rd_entry;
            cand_elapsed_reg <= rd_elapsed;
            prod_cand_reg    <= 64'(rd_entry.frames_done) * 64'(best_elapsed_reg);
            prod_best_reg    <= 64'(best_reg.frames_done) * 64'(rd_elapsed);
            ceil_reg         <= 60'(lsr_pkg::RATIO_CEIL) * 60'(rd_den);
        end
        if (take) begin
            best_reg         <= cand_reg;
            best_elapsed_reg <= cand_elapsed_reg;
            best_idx_reg     <= idx_reg;
        end
        if (res_load) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = lsr_pkg::OUT_DATA_W'(res_reg);

    assign status.slot_free = !active_reg[idx_reg];
    assign status.idx_last  = (idx_reg == SW'(SLOT_COUNT - 1));
    assign status.can_out   = !m_valid_reg || m_tready;

    `LSR_ASSERT_IMPL(a_result_room, aclk, aresetn, res_load, !m_valid_reg || m_tready)
    `LSR_ASSERT_NEXT(a_add_sets_active, aclk, aresetn, cmd.add_commit, active_reg[idx_reg])
    `LSR_ASSERT_NEXT(a_release_clears, aclk, aresetn, upd_fire && release_best, !active_reg[best_idx_reg] && !cancel_reg[best_idx_reg])

endmodule
